// File: rtl/core/stle_pkg.sv
// package for the sorted tick list engine
// sizes, codes and the structs between the sequencer and the link memory
// no dependencies
`timescale 1ns / 1ps

package stle_pkg;

  localparam int NODES  = 16;
  localparam int KEY_W  = 32;
  localparam int NODE_W = 4;
  localparam int IDX_W  = $clog2(NODES + 1);
  localparam int CNT_W  = $clog2(NODES + 1);

  localparam logic [IDX_W-1:0] END_MARK = IDX_W'(NODES);
  localparam logic [KEY_W-1:0] KEY_MAX  = {KEY_W{1'b1}};

  localparam logic [1:0] MODE_SORTED = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_LINKED     = 2'd1;
  localparam logic [1:0] ST_NOT_LINKED = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    idx_t next_ra;
    idx_t prev_ra;
    idx_t key_ra;
    logic next_we;
    idx_t next_wa;
    idx_t next_wd;
    logic prev_we;
    idx_t prev_wa;
    idx_t prev_wd;
    logic key_we;
    idx_t key_wa;
    key_t key_wd;
  } mem_req_t;

  typedef struct packed {
    idx_t next_q;
    idx_t prev_q;
    key_t key_q;
  } mem_rsp_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    idx_t             head;
    key_t             head_key;
    logic             empty;
  } result_t;

endpackage

// File: rtl/core/stle_link_mem.sv
// link and key storage: next, prev and key memories, registered read
// next and prev entries read as the end marker until first written
// depends on stle_pkg
`timescale 1ns / 1ps

module stle_link_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  stle_pkg::mem_req_t req,
  output stle_pkg::mem_rsp_t rsp
);

  localparam int DEPTH = stle_pkg::NODES + 1;

  stle_pkg::idx_t next_mem [DEPTH];
  stle_pkg::idx_t prev_mem [DEPTH];
  stle_pkg::key_t key_mem  [DEPTH];

  logic [DEPTH-1:0] next_vld_r;
  logic [DEPTH-1:0] prev_vld_r;

  stle_pkg::idx_t next_q_r;
  stle_pkg::idx_t prev_q_r;
  stle_pkg::key_t key_q_r;
  logic           next_hit_r;
  logic           prev_hit_r;
  logic           key_end_r;

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_wa] <= req.next_wd;
    end
    if (req.prev_we) begin
      prev_mem[req.prev_wa] <= req.prev_wd;
    end
    if (req.key_we) begin
      key_mem[req.key_wa] <= req.key_wd;
    end
    next_q_r   <= next_mem[req.next_ra];
    prev_q_r   <= prev_mem[req.prev_ra];
    key_q_r    <= key_mem[req.key_ra];
    next_hit_r <= next_vld_r[req.next_ra];
    prev_hit_r <= prev_vld_r[req.prev_ra];
    key_end_r  <= (req.key_ra == stle_pkg::END_MARK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vld_r <= '0;
      prev_vld_r <= '0;
    end else begin
      if (req.next_we) begin
        next_vld_r[req.next_wa] <= 1'b1;
      end
      if (req.prev_we) begin
        prev_vld_r[req.prev_wa] <= 1'b1;
      end
    end
  end

  assign rsp.next_q = next_hit_r ? next_q_r : stle_pkg::END_MARK;
  assign rsp.prev_q = prev_hit_r ? prev_q_r : stle_pkg::END_MARK;
  assign rsp.key_q  = key_end_r ? stle_pkg::KEY_MAX : key_q_r;

endmodule

// File: rtl/core/stle_ctrl.sv
// sequencer: walks and relinks the list through the link memory
// holds linked flags, node count and cursor; presents one result per word
// depends on stle_pkg
`timescale 1ns / 1ps

module stle_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [stle_pkg::NODE_W-1:0] in_node,
  input  stle_pkg::key_t             in_key,
  output logic                       res_valid,
  input  logic                       res_ready,
  output stle_pkg::result_t          res,
  output stle_pkg::mem_req_t         mreq,
  input  stle_pkg::mem_rsp_t         mrsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_R1   = 4'd1;
  localparam logic [3:0] S_R2   = 4'd2;
  localparam logic [3:0] S_KW   = 4'd3;
  localparam logic [3:0] S_A1   = 4'd4;
  localparam logic [3:0] S_A2   = 4'd5;
  localparam logic [3:0] S_W0   = 4'd6;
  localparam logic [3:0] S_WK   = 4'd7;
  localparam logic [3:0] S_L1   = 4'd8;
  localparam logic [3:0] S_L2   = 4'd9;
  localparam logic [3:0] S_H1   = 4'd10;
  localparam logic [3:0] S_H2   = 4'd11;
  localparam logic [3:0] S_H3   = 4'd12;

  localparam int CW = stle_pkg::CNT_W;

  logic [3:0]                  state_r, state_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic [stle_pkg::NODE_W-1:0] node_r, node_nxt;
  stle_pkg::key_t              key_r, key_nxt;
  logic [1:0]                  status_r, status_nxt;
  stle_pkg::idx_t              it_r, it_nxt;
  stle_pkg::idx_t              nx_r, nx_nxt;
  stle_pkg::idx_t              a_r, a_nxt;
  stle_pkg::idx_t              b_r, b_nxt;
  stle_pkg::idx_t              head_r, head_nxt;
  logic [stle_pkg::NODES-1:0]  linked_r, linked_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  stle_pkg::idx_t              cursor_r, cursor_nxt;
  stle_pkg::idx_t              nidx;

  assign nidx     = stle_pkg::idx_t'(node_r);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    node_nxt   = node_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    it_nxt     = it_r;
    nx_nxt     = nx_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    head_nxt   = head_r;
    linked_nxt = linked_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;

    mreq         = '0;
    mreq.next_ra = stle_pkg::END_MARK;
    mreq.prev_ra = stle_pkg::END_MARK;
    mreq.key_ra  = stle_pkg::END_MARK;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          node_nxt   = in_node;
          key_nxt    = in_key;
          status_nxt = stle_pkg::ST_OK;
          state_nxt  = S_H1;
          if (in_mode == stle_pkg::MODE_REMOVE) begin
            if (linked_r[in_node]) begin
              state_nxt = S_R1;
            end else begin
              status_nxt = stle_pkg::ST_NOT_LINKED;
            end
          end else if (in_mode == stle_pkg::MODE_SORTED ||
                       in_mode == stle_pkg::MODE_APPEND) begin
            if (linked_r[in_node]) begin
              status_nxt = stle_pkg::ST_LINKED;
            end else begin
              state_nxt = S_KW;
            end
          end
        end
      end
      S_R1: begin
        mreq.next_ra = nidx;
        mreq.prev_ra = nidx;
        state_nxt    = S_R2;
      end
      S_R2: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = mrsp.prev_q;
        mreq.next_wd = mrsp.next_q;
        mreq.prev_we = 1'b1;
        mreq.prev_wa = mrsp.next_q;
        mreq.prev_wd = mrsp.prev_q;
        if (cursor_r == nidx) begin
          cursor_nxt = mrsp.prev_q;
        end
        linked_nxt[node_r] = 1'b0;
        if (count_r != '0) begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_H1;
      end
      S_KW: begin
        mreq.key_we = 1'b1;
        mreq.key_wa = nidx;
        mreq.key_wd = key_r;
        it_nxt      = stle_pkg::END_MARK;
        if (mode_r == stle_pkg::MODE_APPEND) begin
          mreq.prev_ra = cursor_r;
          state_nxt    = S_A1;
        end else if (key_r == stle_pkg::KEY_MAX) begin
          mreq.prev_ra = stle_pkg::END_MARK;
          state_nxt    = S_A1;
        end else begin
          mreq.next_ra = stle_pkg::END_MARK;
          state_nxt    = S_W0;
        end
      end
      S_A1: begin
        a_nxt        = mrsp.prev_q;
        mreq.next_ra = mrsp.prev_q;
        state_nxt    = S_A2;
      end
      S_A2: begin
        b_nxt     = mrsp.next_q;
        state_nxt = S_L1;
      end
      S_W0: begin
        nx_nxt       = mrsp.next_q;
        mreq.next_ra = mrsp.next_q;
        mreq.key_ra  = mrsp.next_q;
        state_nxt    = S_WK;
      end
      S_WK: begin
        mreq.next_ra = mrsp.next_q;
        mreq.key_ra  = mrsp.next_q;
        if (mrsp.key_q <= key_r) begin
          it_nxt = nx_r;
          nx_nxt = mrsp.next_q;
        end else begin
          a_nxt     = it_r;
          b_nxt     = nx_r;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = nidx;
        mreq.next_wd = b_r;
        mreq.prev_we = 1'b1;
        mreq.prev_wa = nidx;
        mreq.prev_wd = a_r;
        state_nxt    = S_L2;
      end
      S_L2: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = a_r;
        mreq.next_wd = nidx;
        mreq.prev_we = 1'b1;
        mreq.prev_wa = b_r;
        mreq.prev_wd = nidx;
        linked_nxt[node_r] = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_H1;
      end
      S_H1: begin
        mreq.next_ra = stle_pkg::END_MARK;
        state_nxt    = S_H2;
      end
      S_H2: begin
        head_nxt    = mrsp.next_q;
        mreq.key_ra = mrsp.next_q;
        state_nxt   = S_H3;
      end
      S_H3: begin
        mreq.key_ra = head_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid    = (state_r == S_H3);
  assign res.status   = status_r;
  assign res.count    = count_r;
  assign res.empty    = (count_r == '0);
  assign res.head     = (count_r == '0) ? stle_pkg::END_MARK : head_r;
  assign res.head_key = (count_r == '0 || head_r == stle_pkg::END_MARK) ?
                        stle_pkg::KEY_MAX : mrsp.key_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      linked_r <= '0;
      count_r  <= '0;
      cursor_r <= stle_pkg::END_MARK;
    end else begin
      state_r  <= state_nxt;
      linked_r <= linked_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    node_r   <= node_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    it_r     <= it_nxt;
    nx_r     <= nx_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    head_r   <= head_nxt;
  end

endmodule

// File: rtl/core/sorted_tick_list_engine.sv
// sorted tick list engine top level: sequencer, link memory, output register
// depends on stle_pkg, stle_link_mem, stle_ctrl
//
// usage
// one circular doubly linked list of 16 nodes with 32-bit keys behind an end marker
// input word: in_tuser selects sorted insert, append before cursor or remove;
// in_tdata carries the node number and the key
// each input word yields exactly one output word: status in out_tuser, and in
// out_tdata the node count, head node, head key and an empty flag
// a remove reads the node's links and joins its two neighbours; an append or an
// all-ones key links the node before the cursor or before the end marker; a sorted
// insert walks from the head past at most 15 nodes; every word then reads the head
// node and its key
// the sorted walk reads one next link and one key a cycle from the link memory
// in_tready is high only while no word is in progress
// the result sits in an output register: the next word is taken while it waits,
// but a finished word holds in the sequencer until out_tready frees the register
// reset empties the list and puts the cursor on the end marker at once, with
// no clearing pass
`timescale 1ns / 1ps

module sorted_tick_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // node_id[3:0], sort_key[35:4], zero pad
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // remaining_count[4:0], head_node[9:5],
                                  // head_key[41:10], is_empty[42], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  stle_pkg::mem_req_t mreq;
  stle_pkg::mem_rsp_t mrsp;
  stle_pkg::result_t  res;
  logic               res_valid;
  logic               res_ready;

  logic               out_valid_r;
  stle_pkg::result_t  out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  stle_link_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  stle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_node   (in_tdata[3:0]),
    .in_key    (in_tdata[35:4]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .mrsp      (mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'd0, out_res_r.empty, out_res_r.head_key,
                       out_res_r.head, out_res_r.count};

endmodule

// File: bench/sorted_tick_list_engine_tb.sv
// testbench for sorted_tick_list_engine: directed and random list operations,
// each output word checked against a tracker of the linked list state
// depends on stle_pkg and the sorted_tick_list_engine rtl
`timescale 1ns / 1ps

module sorted_tick_list_engine_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  class tick_list_tracker;
    stle_pkg::idx_t    succ [stle_pkg::NODES+1];
    stle_pkg::idx_t    pred [stle_pkg::NODES+1];
    stle_pkg::key_t    keys [stle_pkg::NODES+1];
    bit                linked [stle_pkg::NODES];
    int                count;
    stle_pkg::idx_t    cursor;
    stle_pkg::result_t expected_q[$];
    int                errors;
    int                checked;
    int                mode_seen [4];
    int                status_seen [3];
    int                max_fill;

    function new();
      for (int i = 0; i <= stle_pkg::NODES; i++) begin
        succ[i] = stle_pkg::END_MARK;
        pred[i] = stle_pkg::END_MARK;
        keys[i] = '0;
      end
      keys[stle_pkg::END_MARK] = stle_pkg::KEY_MAX;
      foreach (linked[i]) linked[i] = 1'b0;
      count = 0;
      cursor = stle_pkg::END_MARK;
    endfunction

    function void link_after(stle_pkg::idx_t a, stle_pkg::idx_t n);
      stle_pkg::idx_t b;
      b = succ[a];
      succ[n] = b;
      pred[b] = n;
      pred[n] = a;
      succ[a] = n;
      linked[n] = 1'b1;
      count++;
    endfunction

    function void note_word(logic [1:0] mode, logic [3:0] id, stle_pkg::key_t key);
      stle_pkg::idx_t    n, p, s, it, head;
      int                steps;
      logic [1:0]        st;
      stle_pkg::result_t r;
      st = stle_pkg::ST_OK;
      n = {1'b0, id};
      if (mode == stle_pkg::MODE_REMOVE) begin
        if (!linked[n]) begin
          st = stle_pkg::ST_NOT_LINKED;
        end else begin
          p = pred[n];
          s = succ[n];
          pred[s] = p;
          succ[p] = s;
          if (cursor == n) cursor = p;
          linked[n] = 1'b0;
          if (count > 0) count--;
        end
      end else if (mode == stle_pkg::MODE_SORTED || mode == stle_pkg::MODE_APPEND) begin
        if (linked[n]) begin
          st = stle_pkg::ST_LINKED;
        end else begin
          keys[n] = key;
          if (mode == stle_pkg::MODE_APPEND) begin
            it = pred[cursor];
          end else if (key == stle_pkg::KEY_MAX) begin
            it = pred[stle_pkg::END_MARK];
          end else begin
            // walk past every node whose key is not above the new one
            it = stle_pkg::END_MARK;
            steps = 0;
            while (steps < stle_pkg::NODES && keys[succ[it]] <= key) begin
              it = succ[it];
              steps++;
            end
          end
          link_after(it, n);
        end
      end
      head = (count == 0) ? stle_pkg::END_MARK : succ[stle_pkg::END_MARK];
      r.status   = st;
      r.count    = count[4:0];
      r.head     = head;
      r.head_key = (head == stle_pkg::END_MARK) ? stle_pkg::KEY_MAX : keys[head];
      r.empty    = (count == 0);
      expected_q.push_back(r);
      mode_seen[mode]++;
      status_seen[st]++;
      if (count > max_fill) max_fill = count;
    endfunction

    function void check_word(logic [1:0] st, logic [47:0] data);
      stle_pkg::result_t r;
      if (expected_q.size() == 0) begin
        $error("output word with nothing expected: tuser %0d tdata %h", st, data);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      checked++;
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (data[4:0] !== r.count) begin
        $error("remaining_count: expected %0d, got %0d", r.count, data[4:0]);
        errors++;
      end
      if (data[9:5] !== r.head) begin
        $error("head_node: expected %0d, got %0d", r.head, data[9:5]);
        errors++;
      end
      if (data[41:10] !== r.head_key) begin
        $error("head_key: expected %h, got %h", r.head_key, data[41:10]);
        errors++;
      end
      if (data[42] !== r.empty) begin
        $error("is_empty: expected %0d, got %0d", r.empty, data[42]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [3:0] pick_node(bit want_linked);
      logic [3:0] cand[$];
      for (int i = 0; i < stle_pkg::NODES; i++) begin
        if (linked[i] == want_linked) cand.push_back(i[3:0]);
      end
      if (cand.size() == 0) return 4'($urandom_range(stle_pkg::NODES - 1));
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // node_id[3:0], sort_key[35:4], zero pad
  logic [1:0]  in_tuser = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // remaining_count[4:0], head_node[9:5],
                                // head_key[41:10], is_empty[42], zero pad
  logic [1:0]  out_tuser;       // status[1:0]

  tick_list_tracker tracker = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  sorted_tick_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sorted_tick_list_engine: FAILED **");
    $finish;
  end

  // result side: checks accepted words, stalls at random or for a hold-off
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_word(out_tuser, out_tdata);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_word(logic [1:0] mode, logic [3:0] id, stle_pkg::key_t key);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, key, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_word(mode, id, key);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic run_random(int n_words);
    int             fill_bias;
    logic [1:0]     mode;
    logic [3:0]     id;
    stle_pkg::key_t key;
    for (int i = 0; i < n_words; i++) begin
      // alternate filling and draining stretches so the list reaches both ends
      fill_bias = ((i / 64) % 2 == 0) ? 75 : 30;
      if ($urandom_range(99) < 3) begin
        mode = MODE_UNUSED;
      end else if ($urandom_range(99) < fill_bias) begin
        mode = ($urandom_range(3) == 0) ? stle_pkg::MODE_APPEND : stle_pkg::MODE_SORTED;
      end else begin
        mode = stle_pkg::MODE_REMOVE;
      end
      if ($urandom_range(99) < 85) id = tracker.pick_node(mode == stle_pkg::MODE_REMOVE);
      else id = 4'($urandom_range(15));
      case ($urandom_range(9))
        0:       key = '0;
        1:       key = stle_pkg::KEY_MAX;
        2:       key = stle_pkg::KEY_MAX - 1;
        3, 4, 5: key = stle_pkg::key_t'($urandom_range(7));
        6:       key = stle_pkg::key_t'($urandom_range(1000));
        default: key = stle_pkg::key_t'($urandom);
      endcase
      send_word(mode, id, key);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(stle_pkg::MODE_REMOVE, 4'd0, '0);
    send_word(stle_pkg::MODE_SORTED, 4'd3, 32'd100);
    send_word(stle_pkg::MODE_SORTED, 4'd5, 32'd50);
    send_word(stle_pkg::MODE_SORTED, 4'd7, 32'd100);
    send_word(stle_pkg::MODE_SORTED, 4'd9, stle_pkg::KEY_MAX);
    send_word(stle_pkg::MODE_SORTED, 4'd0, '0);
    send_word(stle_pkg::MODE_SORTED, 4'd12, stle_pkg::KEY_MAX - 1);
    send_word(stle_pkg::MODE_APPEND, 4'd15, 32'h5555_aaaa);
    send_word(stle_pkg::MODE_APPEND, 4'd1, '0);
    send_word(stle_pkg::MODE_APPEND, 4'd14, stle_pkg::KEY_MAX);
    send_word(stle_pkg::MODE_SORTED, 4'd3, 32'd7);
    send_word(stle_pkg::MODE_APPEND, 4'd5, 32'd7);
    send_word(MODE_UNUSED, 4'd2, 32'haaaa_5555);
    send_word(stle_pkg::MODE_REMOVE, 4'd2, '0);
    send_word(stle_pkg::MODE_REMOVE, 4'd0, '0);
    send_word(stle_pkg::MODE_REMOVE, 4'd14, '0);
    send_word(stle_pkg::MODE_REMOVE, 4'd9, '0);
    send_word(stle_pkg::MODE_SORTED, 4'd9, 32'd100);
    for (int i = 0; i < 16; i += 3) send_word(stle_pkg::MODE_REMOVE, i[3:0], '0);
    send_word(stle_pkg::MODE_REMOVE, 4'd5, '0);
    drain();

    send_idle = 38;
    recv_idle = 48;
    run_random(330);
    drain();

    send_idle = 48;
    recv_idle = 38;
    run_random(330);
    drain();

    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 200;
    run_random(15);
    drain();
    run_random(330);

    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d words: %0d sorted, %0d append, %0d remove, %0d unused mode",
             tracker.checked, tracker.mode_seen[stle_pkg::MODE_SORTED],
             tracker.mode_seen[stle_pkg::MODE_APPEND],
             tracker.mode_seen[stle_pkg::MODE_REMOVE], tracker.mode_seen[MODE_UNUSED]);
    $display("statuses ok/linked/not linked %0d/%0d/%0d, deepest list %0d of %0d nodes",
             tracker.status_seen[stle_pkg::ST_OK], tracker.status_seen[stle_pkg::ST_LINKED],
             tracker.status_seen[stle_pkg::ST_NOT_LINKED], tracker.max_fill,
             stle_pkg::NODES);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** sorted_tick_list_engine: PASSED **");
    end else begin
      $display("** sorted_tick_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

// File: sorted_tick_list_engine.f
rtl/core/stle_pkg.sv
rtl/core/stle_link_mem.sv
rtl/core/stle_ctrl.sv
rtl/core/sorted_tick_list_engine.sv
bench/sorted_tick_list_engine_tb.sv
